// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent property wrappers used by the top-level RTL, removable with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== hw/rtl/qcct_pkg.sv =====
// ----------------------------------------------------------------------------
// qcct_pkg
// Types and constants of the QUIC connection credit tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package qcct_pkg;

  localparam int unsigned DATA_W     = 62;
  localparam int unsigned STREAM_W   = 61;
  localparam int unsigned BYTES_W    = 32;
  localparam int unsigned CFG_DATA_W = 62;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [DATA_W-1:0]   DATA_MAX   = {DATA_W{1'b1}};
  localparam logic [STREAM_W-1:0] STREAM_CAP = {1'b1, {(STREAM_W-1){1'b0}}};

  localparam logic [BYTES_W-1:0] DATA_THRESHOLD_RST = 32'd8912;
  localparam logic [BYTES_W-1:0] DATA_STEP_RST      = 32'd8912;
  localparam logic [7:0]         STREAM_THRESHOLD_RST = 8'd4;
  localparam logic [7:0]         STREAM_STEP_RST      = 8'd8;

  typedef enum logic [2:0] {
    OP_ADD_SENT     = 3'd0,
    OP_RAISE_LIMIT  = 3'd1,
    OP_CHECK_SEND   = 3'd2,
    OP_ADD_RECV     = 3'd3,
    OP_CHECK_RECV   = 3'd4,
    OP_CHECK_STREAM = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    FRAME_NONE             = 3'd0,
    FRAME_DATA_BLOCKED     = 3'd1,
    FRAME_MAX_DATA         = 3'd2,
    FRAME_MAX_STREAMS_BIDI = 3'd3,
    FRAME_MAX_STREAMS_UNI  = 3'd4
  } frame_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INITIAL_MAX_DATA         = 3'd0,
    REG_INITIAL_MAX_STREAMS_BIDI = 3'd1,
    REG_INITIAL_MAX_STREAMS_UNI  = 3'd2,
    REG_DATA_LOW_THRESHOLD       = 3'd3,
    REG_DATA_WINDOW_STEP         = 3'd4,
    REG_STREAM_LOW_THRESHOLD     = 3'd5,
    REG_STREAM_LIMIT_STEP        = 3'd6
  } reg_index_t;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_ADD_SENT,
    CMD_RAISE_LIMIT,
    CMD_CHECK_SEND,
    CMD_ADD_RECV,
    CMD_CHECK_RECV,
    CMD_STREAM_BIDI,
    CMD_STREAM_UNI
  } cmd_kind_t;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [BYTES_W-1:0] byte_count;
    logic [DATA_W-1:0]  offered_limit;
    logic [DATA_W-1:0]  peer_stream_id;
  } event_t;

  typedef struct packed {
    logic              allowed;
    logic [2:0]        frame_kind;
    logic [DATA_W-1:0] frame_value;
    logic [DATA_W-1:0] send_credit;
  } result_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [DATA_W-1:0] operand;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/qcct_chan_if.sv =====
// ----------------------------------------------------------------------------
// qcct_chan_if
// Valid/ready channel carrying one item of type T.
// ----------------------------------------------------------------------------
`default_nettype none

interface qcct_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/qcct_front.sv =====
// ----------------------------------------------------------------------------
// qcct_front
// Classifies incoming events into commands with a single operand.
// ----------------------------------------------------------------------------
`default_nettype none

module qcct_front (
  qcct_chan_if.sink   evt,
  qcct_chan_if.source cmd
);

  qcct_pkg::cmd_t decoded;

  always_comb begin
    decoded.kind    = qcct_pkg::CMD_NOP;
    decoded.operand = '0;
    unique case (evt.data.opcode)
      qcct_pkg::OP_ADD_SENT: begin
        decoded.kind    = qcct_pkg::CMD_ADD_SENT;
        decoded.operand = qcct_pkg::DATA_W'(evt.data.byte_count);
      end
      qcct_pkg::OP_RAISE_LIMIT: begin
        decoded.kind    = qcct_pkg::CMD_RAISE_LIMIT;
        decoded.operand = evt.data.offered_limit;
      end
      qcct_pkg::OP_CHECK_SEND: begin
        decoded.kind = qcct_pkg::CMD_CHECK_SEND;
      end
      qcct_pkg::OP_ADD_RECV: begin
        decoded.kind    = qcct_pkg::CMD_ADD_RECV;
        decoded.operand = qcct_pkg::DATA_W'(evt.data.byte_count);
      end
      qcct_pkg::OP_CHECK_RECV: begin
        decoded.kind = qcct_pkg::CMD_CHECK_RECV;
      end
      qcct_pkg::OP_CHECK_STREAM: begin
        // bit 1 of the stream ID picks the direction
        decoded.kind    = evt.data.peer_stream_id[1] ? qcct_pkg::CMD_STREAM_UNI
                                                     : qcct_pkg::CMD_STREAM_BIDI;
        decoded.operand = evt.data.peer_stream_id;
      end
      default: begin
        decoded.kind = qcct_pkg::CMD_NOP;
      end
    endcase
  end

  assign cmd.valid = evt.valid;
  assign cmd.data  = decoded;
  assign evt.ready = cmd.ready;

endmodule

`default_nettype wire

// ===== hw/rtl/qcct_queue.sv =====
// ----------------------------------------------------------------------------
// qcct_queue
// Two-entry command queue between the classifier and the executor.
// ----------------------------------------------------------------------------
`default_nettype none

module qcct_queue (
  input  wire logic   clk,
  input  wire logic   rst,
  qcct_chan_if.sink   wr,
  qcct_chan_if.source rd
);

  localparam int unsigned PTR_W = $clog2(qcct_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(qcct_pkg::QUEUE_DEPTH + 1);

  qcct_pkg::cmd_t   entries [qcct_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign wr.ready = (count != CNT_W'(qcct_pkg::QUEUE_DEPTH));
  assign rd.valid = (count != '0);
  assign rd.data  = entries[rd_ptr];
  assign push     = wr.valid && wr.ready;
  assign pop      = rd.valid && rd.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(qcct_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(qcct_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/qcct_back.sv =====
// ----------------------------------------------------------------------------
// qcct_back
// Holds the credit state, executes one command per cycle while the result is not stalled, registers results.
// ----------------------------------------------------------------------------
`default_nettype none

module qcct_back (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [qcct_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [qcct_pkg::CFG_DATA_W-1:0]  cfg_data,
  qcct_chan_if.sink                             cmd,
  qcct_chan_if.source                           res
);

  localparam int unsigned DW = qcct_pkg::DATA_W;
  localparam int unsigned SW = qcct_pkg::STREAM_W;
  localparam int unsigned BW = qcct_pkg::BYTES_W;

  function automatic logic [DW-1:0] sat_add(input logic [DW-1:0] a,
                                            input logic [BW-1:0] b);
    logic [DW:0] sum;
    sum = {1'b0, a} + (DW+1)'(b);
    return sum[DW] ? qcct_pkg::DATA_MAX : sum[DW-1:0];
  endfunction

  // configuration
  logic [BW-1:0] data_low_threshold;
  logic [BW-1:0] data_window_step;
  logic [7:0]    stream_low_threshold;
  logic [7:0]    stream_limit_step;

  // credit state
  logic [DW-1:0] bytes_sent,       bytes_sent_next;
  logic [DW-1:0] send_limit,       send_limit_next;
  logic [DW-1:0] bytes_received,   bytes_received_next;
  logic [DW-1:0] receive_limit,    receive_limit_next;
  logic [SW-1:0] peer_bidi_limit,  peer_bidi_limit_next;
  logic [SW-1:0] peer_uni_limit,   peer_uni_limit_next;
  logic [DW-1:0] peer_bidi_top_id, peer_bidi_top_id_next;
  logic [DW-1:0] peer_uni_top_id,  peer_uni_top_id_next;

  // output register
  logic               res_valid;
  qcct_pkg::result_t  res_data;
  qcct_pkg::result_t  result;
  logic               take;

  // datapath terms
  logic [DW-1:0] send_credit;
  logic [DW-1:0] recv_headroom;
  logic          stream_uni;
  logic [DW-1:0] top_cur;
  logic [DW-1:0] top_new;
  logic [SW-1:0] limit_cur;
  logic [SW-1:0] limit_new;
  logic [SW-1:0] stream_count;
  logic [SW-1:0] stream_headroom;
  logic [SW:0]   limit_sum;
  logic          stream_low;

  assign take      = cmd.valid && cmd.ready;
  assign cmd.ready = !res_valid || res.ready;
  assign res.valid = res_valid;
  assign res.data  = res_data;

  assign send_credit   = send_limit - bytes_sent;
  assign recv_headroom = receive_limit - bytes_received;

  assign stream_uni      = (cmd.data.kind == qcct_pkg::CMD_STREAM_UNI);
  assign top_cur         = stream_uni ? peer_uni_top_id : peer_bidi_top_id;
  assign limit_cur       = stream_uni ? peer_uni_limit  : peer_bidi_limit;
  assign top_new         = (cmd.data.operand > top_cur) ? cmd.data.operand : top_cur;
  assign stream_count    = SW'(top_new[DW-1:2]);
  assign stream_headroom = limit_cur - stream_count;
  assign stream_low      = (stream_headroom[SW-1:8] == '0) &&
                           (stream_headroom[7:0] < stream_low_threshold);
  assign limit_sum       = {1'b0, limit_cur} + (SW+1)'(stream_limit_step);

  always_comb begin
    if (limit_cur >= qcct_pkg::STREAM_CAP) begin
      limit_new = limit_cur;
    end else if (limit_sum > (SW+1)'(qcct_pkg::STREAM_CAP)) begin
      limit_new = qcct_pkg::STREAM_CAP;
    end else begin
      limit_new = limit_sum[SW-1:0];
    end
  end

  always_comb begin
    bytes_sent_next       = bytes_sent;
    send_limit_next       = send_limit;
    bytes_received_next   = bytes_received;
    receive_limit_next    = receive_limit;
    peer_bidi_limit_next  = peer_bidi_limit;
    peer_uni_limit_next   = peer_uni_limit;
    peer_bidi_top_id_next = peer_bidi_top_id;
    peer_uni_top_id_next  = peer_uni_top_id;
    result.allowed        = 1'b1;
    result.frame_kind     = qcct_pkg::FRAME_NONE;
    result.frame_value    = '0;
    result.send_credit    = '0;
    unique case (cmd.data.kind)
      qcct_pkg::CMD_ADD_SENT: begin
        bytes_sent_next = sat_add(bytes_sent, cmd.data.operand[BW-1:0]);
      end
      qcct_pkg::CMD_RAISE_LIMIT: begin
        if (cmd.data.operand > send_limit) begin
          send_limit_next = cmd.data.operand;
        end
      end
      qcct_pkg::CMD_CHECK_SEND: begin
        if (bytes_sent >= send_limit) begin
          result.allowed     = 1'b0;
          result.frame_kind  = qcct_pkg::FRAME_DATA_BLOCKED;
          result.frame_value = send_limit;
        end else begin
          result.send_credit = send_credit;
          if ((send_credit[DW-1:BW] == '0) && (send_credit[BW-1:0] < data_low_threshold)) begin
            result.frame_kind  = qcct_pkg::FRAME_DATA_BLOCKED;
            result.frame_value = send_limit;
          end
        end
      end
      qcct_pkg::CMD_ADD_RECV: begin
        bytes_received_next = sat_add(bytes_received, cmd.data.operand[BW-1:0]);
      end
      qcct_pkg::CMD_CHECK_RECV: begin
        if (bytes_received >= receive_limit) begin
          result.allowed = 1'b0;
        end else if ((recv_headroom[DW-1:BW] == '0) &&
                     (recv_headroom[BW-1:0] < data_low_threshold)) begin
          receive_limit_next = sat_add(receive_limit, data_window_step);
          result.frame_kind  = qcct_pkg::FRAME_MAX_DATA;
          result.frame_value = receive_limit_next;
        end
      end
      qcct_pkg::CMD_STREAM_BIDI, qcct_pkg::CMD_STREAM_UNI: begin
        if (stream_uni) begin
          peer_uni_top_id_next = top_new;
        end else begin
          peer_bidi_top_id_next = top_new;
        end
        if (limit_cur < stream_count) begin
          result.allowed = 1'b0;
        end else if (stream_low) begin
          if (stream_uni) begin
            peer_uni_limit_next = limit_new;
            result.frame_kind   = qcct_pkg::FRAME_MAX_STREAMS_UNI;
          end else begin
            peer_bidi_limit_next = limit_new;
            result.frame_kind    = qcct_pkg::FRAME_MAX_STREAMS_BIDI;
          end
          result.frame_value = DW'(limit_new);
        end
      end
      default: begin
        result.allowed = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data_low_threshold   <= qcct_pkg::DATA_THRESHOLD_RST;
      data_window_step     <= qcct_pkg::DATA_STEP_RST;
      stream_low_threshold <= qcct_pkg::STREAM_THRESHOLD_RST;
      stream_limit_step    <= qcct_pkg::STREAM_STEP_RST;
      bytes_sent           <= '0;
      send_limit           <= '0;
      bytes_received       <= '0;
      receive_limit        <= '0;
      peer_bidi_limit      <= '0;
      peer_uni_limit       <= '0;
      peer_bidi_top_id     <= '0;
      peer_uni_top_id      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        qcct_pkg::REG_INITIAL_MAX_DATA: begin
          send_limit    <= cfg_data[DW-1:0];
          receive_limit <= cfg_data[DW-1:0];
        end
        qcct_pkg::REG_INITIAL_MAX_STREAMS_BIDI: peer_bidi_limit <= cfg_data[SW-1:0];
        qcct_pkg::REG_INITIAL_MAX_STREAMS_UNI:  peer_uni_limit  <= cfg_data[SW-1:0];
        qcct_pkg::REG_DATA_LOW_THRESHOLD:   data_low_threshold   <= cfg_data[BW-1:0];
        qcct_pkg::REG_DATA_WINDOW_STEP:     data_window_step     <= cfg_data[BW-1:0];
        qcct_pkg::REG_STREAM_LOW_THRESHOLD: stream_low_threshold <= cfg_data[7:0];
        qcct_pkg::REG_STREAM_LIMIT_STEP:    stream_limit_step    <= cfg_data[7:0];
        default: ;
      endcase
    end else if (take) begin
      bytes_sent       <= bytes_sent_next;
      send_limit       <= send_limit_next;
      bytes_received   <= bytes_received_next;
      receive_limit    <= receive_limit_next;
      peer_bidi_limit  <= peer_bidi_limit_next;
      peer_uni_limit   <= peer_uni_limit_next;
      peer_bidi_top_id <= peer_bidi_top_id_next;
      peer_uni_top_id  <= peer_uni_top_id_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_data <= result;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/quic_connection_credit_tracker.sv =====
// ----------------------------------------------------------------------------
// quic_connection_credit_tracker
// QUIC connection-level send, receive and peer stream credit tracking.
//
//   channel  dir  payload    handshake
//   evt      in   event_t    valid/ready
//   res      out  result_t   valid/ready
//   cfg      in   index+data write enable, no back-pressure
//
// One event enters per cycle and one result leaves per cycle when both sides
// flow; an event passes through a queue entry and then the output register.
// The rate is set by the executor, which updates all credit state for a command at once.
// The two-entry queue and the output register let either side stall alone.
// Reset is synchronous; there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module quic_connection_credit_tracker (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [qcct_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [qcct_pkg::CFG_DATA_W-1:0]  cfg_data,
  qcct_chan_if.sink                             evt,
  qcct_chan_if.source                           res
);

  qcct_chan_if #(.T(qcct_pkg::cmd_t)) front_cmd ();
  qcct_chan_if #(.T(qcct_pkg::cmd_t)) back_cmd ();

  qcct_front u_front (
    .evt (evt),
    .cmd (front_cmd)
  );

  qcct_queue u_queue (
    .clk (clk),
    .rst (rst),
    .wr  (front_cmd),
    .rd  (back_cmd)
  );

  qcct_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (back_cmd),
    .res       (res)
  );

  `ASSERT_NEXT(a_issue_gives_result, clk, rst, back_cmd.valid && back_cmd.ready, res.valid)
  `ASSERT_IMPLIES(a_no_issue_on_stall, clk, rst, res.valid && !res.ready, !back_cmd.ready)
  `ASSERT_IMPLIES(a_idle_after_reset, clk, 1'b0, $fell(rst), !res.valid)

endmodule

`default_nettype wire
